// ----- hw/rtl/cdsk_pkg.sv -----
`default_nettype none

package cdsk_pkg;

    localparam int unsigned DEF_MAX_CODEBOOKS = 8;
    localparam int unsigned DEF_TOKEN_BITS    = 16;

    localparam int unsigned CFG_IDX_W    = 2;
    localparam int unsigned CFG_DATA_W   = 16;
    localparam int unsigned CFG_ACTIVE_W = 4;
    localparam int unsigned CFG_TOKEN_W  = 16;

    localparam int unsigned SEEN_W = 4;
    localparam logic [SEEN_W-1:0] SEEN_MAX = 4'd15;

    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [CFG_ACTIVE_W-1:0] RST_ACTIVE_CODEBOOKS = 4'd8;
    localparam logic [CFG_TOKEN_W-1:0]  RST_BEGIN_TOKEN      = 16'd1024;
    localparam logic [CFG_TOKEN_W-1:0]  RST_END_TOKEN        = 16'd1025;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ACTIVE_CODEBOOKS = 2'd0,
        CFG_BEGIN_TOKEN      = 2'd1,
        CFG_END_TOKEN        = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic              fin;
        logic [SEEN_W-1:0] seen;
    } t_frame_ctl;

endpackage

`default_nettype wire

// ----- hw/rtl/cdsk_in_if.sv -----
`default_nettype none

interface cdsk_in_if
    import cdsk_pkg::*;
#(
    parameter int unsigned MAX_CODEBOOKS = DEF_MAX_CODEBOOKS,
    parameter int unsigned TOKEN_BITS    = DEF_TOKEN_BITS
) ();
    logic                                valid;
    logic                                ready;
    logic [MAX_CODEBOOKS*TOKEN_BITS-1:0] code;
    logic                                final_frame;

    modport source (output valid, output code, output final_frame, input ready);
    modport sink   (input valid, input code, input final_frame, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/cdsk_out_if.sv -----
`default_nettype none

interface cdsk_out_if
    import cdsk_pkg::*;
#(
    parameter int unsigned MAX_CODEBOOKS = DEF_MAX_CODEBOOKS,
    parameter int unsigned TOKEN_BITS    = DEF_TOKEN_BITS
) ();
    logic                                valid;
    logic                                ready;
    logic [MAX_CODEBOOKS*TOKEN_BITS-1:0] out;
    logic                                sequence_end;

    modport source (output valid, output out, output sequence_end, input ready);
    modport sink   (input valid, input out, input sequence_end, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/codebook_delay_skew.sv -----
// Codebook delay skew: lane k of each token frame is delayed by k frames.
// Input channel i_in takes one frame (one token per lane plus final_frame);
// output channel o_out gives one delayed frame per request, with sequence_end
// set on the last frame of a sequence. Lanes not in use output zero.
// Config port: i_cfg_we writes i_cfg_data to register i_cfg_idx
// (0 active codebooks, 1 begin token, 2 end token); write only while idle.
// Path: an accepted frame is written into the queue, then into the output register on o_out.
// Throughput: one frame per cycle while o_out is not stalled, set by the output stage
// that reads each lane's oldest delay tap. A final frame adds used-1 flush frames
// (used = active codebooks clamped to 1..MAX_CODEBOOKS), one per cycle, while a
// two-entry queue keeps taking input until it fills.
// Reset: frame count cleared, queue and output emptied, registers back to
// 8 codebooks, begin token 1024, end token 1025. History is not cleared.
// Stall: when o_out.ready is low the output frame holds, the queue fills and
// i_in.ready drops; nothing is lost or repeated.
`default_nettype none

module codebook_delay_skew
    import cdsk_pkg::*;
#(
    parameter int unsigned MAX_CODEBOOKS = DEF_MAX_CODEBOOKS,
    parameter int unsigned TOKEN_BITS    = DEF_TOKEN_BITS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    cdsk_in_if.sink                    i_in,
    cdsk_out_if.source                 o_out,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);
    localparam int unsigned LANE_W = $clog2(MAX_CODEBOOKS + 1);
    localparam int unsigned CODE_W = MAX_CODEBOOKS * TOKEN_BITS;
    localparam int unsigned CTL_W  = $bits(t_frame_ctl);
    localparam int unsigned Q_W    = CODE_W + CTL_W;

    logic [CFG_ACTIVE_W-1:0] r_active;
    logic [CFG_TOKEN_W-1:0]  r_begin;
    logic [CFG_TOKEN_W-1:0]  r_end;
    logic [CFG_ACTIVE_W-1:0] used_clamp;
    logic [LANE_W-1:0]       used;

    logic              q_ready;
    logic              q_push;
    logic [CODE_W-1:0] q_wcode;
    t_frame_ctl        q_wctl;
    logic              q_valid;
    logic              q_pop;
    logic [Q_W-1:0]    q_rdata;
    t_frame_ctl        q_rctl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= RST_ACTIVE_CODEBOOKS;
            r_begin  <= RST_BEGIN_TOKEN;
            r_end    <= RST_END_TOKEN;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_ACTIVE_CODEBOOKS: r_active <= i_cfg_data[CFG_ACTIVE_W-1:0];
                CFG_BEGIN_TOKEN:      r_begin  <= i_cfg_data[CFG_TOKEN_W-1:0];
                CFG_END_TOKEN:        r_end    <= i_cfg_data[CFG_TOKEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_active == '0) begin
            used_clamp = CFG_ACTIVE_W'(1);
        end else if (r_active > CFG_ACTIVE_W'(MAX_CODEBOOKS)) begin
            used_clamp = CFG_ACTIVE_W'(MAX_CODEBOOKS);
        end else begin
            used_clamp = r_active;
        end
    end
    assign used = LANE_W'(used_clamp);

    cdsk_front #(
        .MAX_CODEBOOKS (MAX_CODEBOOKS),
        .TOKEN_BITS    (TOKEN_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_q_ready (q_ready),
        .o_q_push  (q_push),
        .o_q_code  (q_wcode),
        .o_q_ctl   (q_wctl)
    );

    cdsk_queue #(
        .DATA_W (Q_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_wdata ({q_wctl, q_wcode}),
        .o_ready (q_ready),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_rdata (q_rdata)
    );

    assign q_rctl = t_frame_ctl'(q_rdata[Q_W-1:CODE_W]);

    cdsk_back #(
        .MAX_CODEBOOKS (MAX_CODEBOOKS),
        .TOKEN_BITS    (TOKEN_BITS),
        .LANE_W        (LANE_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_code    (q_rdata[CODE_W-1:0]),
        .i_q_ctl     (q_rctl),
        .o_q_pop     (q_pop),
        .i_used      (used),
        .i_begin_tok (TOKEN_BITS'(r_begin)),
        .i_end_tok   (TOKEN_BITS'(r_end)),
        .o_out       (o_out)
    );
endmodule

`default_nettype wire

// ----- hw/rtl/cdsk_front.sv -----
`default_nettype none

module cdsk_front
    import cdsk_pkg::*;
#(
    parameter int unsigned MAX_CODEBOOKS = DEF_MAX_CODEBOOKS,
    parameter int unsigned TOKEN_BITS    = DEF_TOKEN_BITS
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    cdsk_in_if.sink                                  i_in,
    input  wire logic                                i_q_ready,
    output logic                                     o_q_push,
    output logic [MAX_CODEBOOKS*TOKEN_BITS-1:0]      o_q_code,
    output t_frame_ctl                               o_q_ctl
);
    localparam logic [TOKEN_BITS-1:0] TOK_MASK = TOKEN_BITS'({CFG_TOKEN_W{1'b1}});

    logic [SEEN_W-1:0] r_seen;
    logic [SEEN_W-1:0] n_seen;
    logic              accept;

    assign i_in.ready = i_q_ready;
    assign accept     = i_in.valid && i_q_ready;
    assign o_q_push   = accept;

    for (genvar k = 0; k < MAX_CODEBOOKS; k++) begin : g_mask
        assign o_q_code[k*TOKEN_BITS +: TOKEN_BITS] =
            i_in.code[k*TOKEN_BITS +: TOKEN_BITS] & TOK_MASK;
    end

    assign o_q_ctl.fin  = i_in.final_frame;
    assign o_q_ctl.seen = r_seen;

    always_comb begin
        n_seen = r_seen;
        if (accept) begin
            if (i_in.final_frame) begin
                n_seen = '0;
            end else if (r_seen != SEEN_MAX) begin
                n_seen = r_seen + SEEN_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
        end else begin
            r_seen <= n_seen;
        end
    end
endmodule

`default_nettype wire

// ----- hw/rtl/cdsk_queue.sv -----
`default_nettype none

module cdsk_queue
    import cdsk_pkg::*;
#(
    parameter int unsigned DATA_W = 1,
    parameter int unsigned DEPTH  = QUEUE_DEPTH
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire logic [DATA_W-1:0] i_wdata,
    output logic                   o_ready,
    input  wire logic              i_pop,
    output logic                   o_valid,
    output logic [DATA_W-1:0]      o_rdata
);
    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wptr;
    logic [PTR_W-1:0]  r_rptr;
    logic [CNT_W-1:0]  r_cnt;
    logic              do_push;
    logic              do_pop;

    assign o_ready = (r_cnt != CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_rdata = r_mem[r_rptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= ptr_inc(r_wptr);
            end
            if (do_pop) begin
                r_rptr <= ptr_inc(r_rptr);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end
endmodule

`default_nettype wire

// ----- hw/rtl/cdsk_back.sv -----
`default_nettype none

module cdsk_back
    import cdsk_pkg::*;
#(
    parameter int unsigned MAX_CODEBOOKS = DEF_MAX_CODEBOOKS,
    parameter int unsigned TOKEN_BITS    = DEF_TOKEN_BITS,
    parameter int unsigned LANE_W        = $clog2(MAX_CODEBOOKS + 1)
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_q_valid,
    input  wire logic [MAX_CODEBOOKS*TOKEN_BITS-1:0] i_q_code,
    input  wire t_frame_ctl                          i_q_ctl,
    output logic                                     o_q_pop,
    input  wire logic [LANE_W-1:0]                   i_used,
    input  wire logic [TOKEN_BITS-1:0]               i_begin_tok,
    input  wire logic [TOKEN_BITS-1:0]               i_end_tok,
    cdsk_out_if.source                               o_out
);
    logic                                r_flush;
    logic [LANE_W-1:0]                   r_j;
    logic [SEEN_W-1:0]                   r_t;
    logic                                r_ovalid;
    logic [MAX_CODEBOOKS*TOKEN_BITS-1:0] r_out;
    logic                                r_send;

    logic                                adv;
    logic                                fire_flush;
    logic                                fire;
    logic [SEEN_W-1:0]                   sel_t;
    logic [MAX_CODEBOOKS*TOKEN_BITS-1:0] n_out;
    logic                                n_send;
    logic                                flush_last;

    assign adv        = !r_ovalid || o_out.ready;
    assign fire_flush = adv && r_flush;
    assign o_q_pop    = adv && !r_flush && i_q_valid;
    assign fire       = fire_flush || o_q_pop;
    assign sel_t      = r_flush ? r_t : i_q_ctl.seen;
    assign flush_last = (r_j + LANE_W'(2)) == i_used;
    assign n_send     = r_flush ? flush_last
                                : (i_q_ctl.fin && (i_used == LANE_W'(1)));

    for (genvar k = 0; k < MAX_CODEBOOKS; k++) begin : g_lane
        logic [TOKEN_BITS-1:0] tap;

        if (k == 0) begin : g_direct
            assign tap = i_q_code[TOKEN_BITS-1:0];
        end else begin : g_delay
            logic [TOKEN_BITS-1:0] r_tap [k];

            // flush cycles keep shifting so the oldest tap walks back through the line
            always_ff @(posedge i_clk) begin
                if (fire) begin
                    r_tap[0] <= i_q_code[k*TOKEN_BITS +: TOKEN_BITS];
                    for (int d = 1; d < k; d++) begin
                        r_tap[d] <= r_tap[d-1];
                    end
                end
            end
            assign tap = r_tap[k-1];
        end

        always_comb begin
            if (LANE_W'(k) >= i_used) begin
                n_out[k*TOKEN_BITS +: TOKEN_BITS] = '0;
            end else if (sel_t < SEEN_W'(k)) begin
                n_out[k*TOKEN_BITS +: TOKEN_BITS] = i_begin_tok;
            end else if (r_flush && (r_j >= LANE_W'(k))) begin
                n_out[k*TOKEN_BITS +: TOKEN_BITS] = i_end_tok;
            end else begin
                n_out[k*TOKEN_BITS +: TOKEN_BITS] = tap;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flush  <= 1'b0;
            r_j      <= '0;
            r_t      <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (adv) begin
                r_ovalid <= fire;
            end
            if (fire_flush) begin
                r_j <= r_j + LANE_W'(1);
                if (r_t != SEEN_MAX) begin
                    r_t <= r_t + SEEN_W'(1);
                end
                if (flush_last) begin
                    r_flush <= 1'b0;
                end
            end else if (o_q_pop && i_q_ctl.fin && (i_used != LANE_W'(1))) begin
                r_flush <= 1'b1;
                r_j     <= '0;
                r_t     <= (i_q_ctl.seen == SEEN_MAX) ? SEEN_MAX
                                                      : i_q_ctl.seen + SEEN_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out  <= n_out;
            r_send <= n_send;
        end
    end

    assign o_out.valid        = r_ovalid;
    assign o_out.out          = r_out;
    assign o_out.sequence_end = r_send;
endmodule

`default_nettype wire
